[rtl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that an implication holds on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

[rtl/rvq_pkg.sv]
// Types, constants and step functions of the rotation vector to quaternion block
package rvq_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN = 24;

    // Square root: 34-bit radicand, 17-bit root
    localparam int SQ_W = 34;
    localparam int ROOT_W = 17;
    localparam int REM_W = ROOT_W + 2;

    // CORDIC datapath in Q30
    localparam int CW = 34;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [31:0] GAIN_Q30 = 32'd652032874;

    // Division of the vector parts
    localparam int Q_W = 16;
    localparam int NUM_W = 50;
    localparam int DEN_W = ROOT_W + 15;
    localparam int LANES = 3;

    localparam int QONE = 16384;

    typedef struct packed {
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
    } rvq_in_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } rvq_out_t;

    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [REM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } rvq_sqrt_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } rvq_cord_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0] q;
        logic neg;
    } rvq_div_t;

    // floor(atan(2^-k) * 2^30)
    function automatic logic [31:0] atan_q30(int k);
        logic [31:0] a;
        case (k)
            0: a = 32'd843314856;
            1: a = 32'd497837829;
            2: a = 32'd263043836;
            3: a = 32'd133525158;
            4: a = 32'd67021686;
            5: a = 32'd33543515;
            6: a = 32'd16775850;
            7: a = 32'd8388437;
            8: a = 32'd4194282;
            9: a = 32'd2097149;
            10: a = 32'd1048575;
            11: a = 32'd524287;
            12: a = 32'd262143;
            13: a = 32'd131071;
            14: a = 32'd65535;
            15: a = 32'd32767;
            16: a = 32'd16383;
            17: a = 32'd8191;
            18: a = 32'd4095;
            19: a = 32'd2047;
            20: a = 32'd1023;
            21: a = 32'd511;
            22: a = 32'd255;
            23: a = 32'd127;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // One digit of the restoring square root: consume two radicand bits
    function automatic rvq_sqrt_t sqrt_step(rvq_sqrt_t s);
        rvq_sqrt_t r;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = {s.rem[REM_W-3:0], s.n[SQ_W-1 -: 2]};
        trial = {s.root, 2'b01};
        r.n = {s.n[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            r.rem = rem_sh - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = rem_sh;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // One rotation-mode CORDIC micro-rotation
    function automatic rvq_cord_t cordic_step(rvq_cord_t s, int k);
        rvq_cord_t r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] a;
        dx = s.y >>> k;
        dy = s.x >>> k;
        a = $signed({2'b00, atan_q30(k)});
        if (s.z >= 0)
        begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.z = s.z - a;
        end
        else
        begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.z = s.z + a;
        end
        return r;
    endfunction

    // One quotient bit of the restoring divider
    function automatic rvq_div_t div_step(rvq_div_t s, logic [DEN_W-1:0] den, int b);
        rvq_div_t r;
        logic [NUM_W-1:0] sh;
        logic [NUM_W:0] diff;
        sh = NUM_W'(den) << b;
        diff = {1'b0, s.rem} - {1'b0, sh};
        r = s;
        if (!diff[NUM_W])
        begin
            r.rem = diff[NUM_W-1:0];
            r.q[b] = 1'b1;
        end
        return r;
    endfunction

endpackage

[rtl/rvq_isqrt.sv]
// Pipelined integer square root, one root bit per stage
module rvq_isqrt import rvq_pkg::*; #(
    parameter int SIDE_W = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_sq,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    rvq_sqrt_t         st_reg   [0:ROOT_W-1];
    logic [SIDE_W-1:0] side_reg [0:ROOT_W-1];
    logic              vld_reg  [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        rvq_sqrt_t         st_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;

        // Select this stage's source
        if (k == 0)
        begin : g_first
            always_comb
            begin
                st_in.n = in_sq;
                st_in.rem = '0;
                st_in.root = '0;
                side_in = in_side;
                vld_in = in_valid;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                st_in = st_reg[k-1];
                side_in = side_reg[k-1];
                vld_in = vld_reg[k-1];
            end
        end

        // Advance valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        // Advance payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= sqrt_step(st_in);
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root = st_reg[ROOT_W-1].root;
    assign out_side = side_reg[ROOT_W-1];

endmodule

[rtl/rvq_cordic.sv]
// Pipelined rotation-mode CORDIC, one micro-rotation per stage
module rvq_cordic import rvq_pkg::*; #(
    parameter int STEPS  = CORDIC_STEPS_DEF,
    parameter int SIDE_W = 67
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  rvq_cord_t         in_cord,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output rvq_cord_t         out_cord,
    output logic [SIDE_W-1:0] out_side
);

    rvq_cord_t         st_reg   [0:STEPS-1];
    logic [SIDE_W-1:0] side_reg [0:STEPS-1];
    logic              vld_reg  [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_stage
        rvq_cord_t         st_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;

        // Select this stage's source
        if (k == 0)
        begin : g_first
            always_comb
            begin
                st_in = in_cord;
                side_in = in_side;
                vld_in = in_valid;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                st_in = st_reg[k-1];
                side_in = side_reg[k-1];
                vld_in = vld_reg[k-1];
            end
        end

        // Advance valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        // Rotate
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= cordic_step(st_in, k);
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_cord = st_reg[STEPS-1];
    assign out_side = side_reg[STEPS-1];

endmodule

[rtl/rvq_divide.sv]
// Pipelined rounding divider for the three vector parts, one quotient bit per stage
module rvq_divide import rvq_pkg::*; #(
    parameter int SIDE_W = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] in_prod [0:LANES-1],
    input  logic [ROOT_W-1:0]       in_root,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic [Q_W-1:0]          out_q   [0:LANES-1],
    output logic                    out_neg [0:LANES-1],
    output logic [SIDE_W-1:0]       out_side
);

    rvq_div_t          dv_reg   [0:Q_W][0:LANES-1];
    logic [DEN_W-1:0]  den_reg  [0:Q_W];
    logic [SIDE_W-1:0] side_reg [0:Q_W];
    logic              vld_reg  [0:Q_W];

    // Prepare magnitude plus half divisor for round-half-away
    rvq_div_t prep [0:LANES-1];
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            prep[l].neg = in_prod[l][NUM_W-1];
            prep[l].rem = (in_prod[l][NUM_W-1] ? NUM_W'(-in_prod[l]) : NUM_W'(in_prod[l]))
                          + NUM_W'({in_root, 14'd0});
            prep[l].q = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= prep;
            den_reg[0] <= {in_root, 15'd0};
            side_reg[0] <= in_side;
        end
    end

    for (genvar s = 1; s <= Q_W; s++)
    begin : g_stage
        // Advance valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_reg[s-1];
        end

        // Resolve one quotient bit in every lane
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < LANES; l++)
                    dv_reg[s][l] <= div_step(dv_reg[s-1][l], den_reg[s-1], Q_W - s);
                den_reg[s] <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_q[l] = dv_reg[Q_W][l].q;
            out_neg[l] = dv_reg[Q_W][l].neg;
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign out_side = side_reg[Q_W];

endmodule

[rtl/rotation_vector_to_quaternion.sv]
// Top level: rotation vector to unit quaternion pipeline
//
// Input channel rot_valid / rot_ready / rot carries one rotation vector
// (rot_x, rot_y, rot_z, signed Q2.13 radians) per beat. Output channel
// quat_valid / quat_ready / quat carries one unit quaternion (quat_w, quat_x,
// quat_y, quat_z, signed Q1.14, saturated to +-16384) per beat, in order.
// Throughput is one beat per cycle while the receiver does not stall. The
// pipeline runs through squaring, square root (one root bit per stage),
// fold, CORDIC (one stage per step), scaling, divider (one quotient bit
// per stage) and output.
// A zero vector yields the identity quaternion.
// Reset clears every valid bit; payload registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and rot_ready drops in the same cycle; nothing is lost or repeated.
module rotation_vector_to_quaternion import rvq_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rot_valid,
    output logic     rot_ready,
    input  rvq_in_t  rot,
    output logic     quat_valid,
    input  logic     quat_ready,
    output rvq_out_t quat
);

    localparam int CSIDE_W = 48 + ROOT_W + 2;
    localparam int DSIDE_W = 17;

    logic en;
    assign en = !quat_valid || quat_ready;
    assign rot_ready = en;

    // Stage A: square the components
    logic               a_vld_reg;
    rvq_in_t            a_c_reg;
    logic [30:0]        a_sq_reg [0:2];
    logic signed [31:0] sq_full [0:2];

    always_comb
    begin
        sq_full[0] = rot.rot_x * rot.rot_x;
        sq_full[1] = rot.rot_y * rot.rot_y;
        sq_full[2] = rot.rot_z * rot.rot_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= rot_valid && rot_ready;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_c_reg <= rot;
            for (int i = 0; i < 3; i++)
                a_sq_reg[i] <= sq_full[i][30:0];
        end
    end

    // Stage B: sum of squares, times four
    logic            b_vld_reg;
    rvq_in_t         b_c_reg;
    logic [SQ_W-1:0] b_n_reg;
    logic [31:0]     sum;

    assign sum = 32'(a_sq_reg[0]) + 32'(a_sq_reg[1]) + 32'(a_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_c_reg <= a_c_reg;
            b_n_reg <= {sum, 2'b00};
        end
    end

    // Square root gives t in Q14, which is also the half angle in Q15
    logic              s_vld;
    logic [ROOT_W-1:0] s_root;
    logic [47:0]       s_side;

    rvq_isqrt #(.SIDE_W(48)) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_vld_reg),
        .in_sq     (b_n_reg),
        .in_side   (b_c_reg),
        .out_valid (s_vld),
        .out_root  (s_root),
        .out_side  (s_side)
    );

    // Stage C: move the half angle to Q30 and fold past pi/2
    logic               c_vld_reg;
    rvq_cord_t          c_cord_reg;
    logic [CSIDE_W-1:0] c_side_reg;
    logic [31:0]        z0;
    logic               fold;

    assign z0 = {s_root, 15'd0};
    assign fold = z0 > HALF_PI_Q30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= s_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_cord_reg.x <= $signed({2'b00, GAIN_Q30});
            c_cord_reg.y <= '0;
            c_cord_reg.z <= fold ? ($signed({2'b00, PI_Q30}) - $signed({2'b00, z0}))
                                 : $signed({2'b00, z0});
            c_side_reg <= {s_side, s_root, fold, s_root == '0};
        end
    end

    // CORDIC sine and cosine of the folded half angle
    logic               k_vld;
    rvq_cord_t          k_cord;
    logic [CSIDE_W-1:0] k_side;

    rvq_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W(CSIDE_W)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_vld_reg),
        .in_cord   (c_cord_reg),
        .in_side   (c_side_reg),
        .out_valid (k_vld),
        .out_cord  (k_cord),
        .out_side  (k_side)
    );

    // Stage D: round the cosine and scale the sine by each component
    rvq_in_t               k_c;
    logic [ROOT_W-1:0]     k_root;
    logic                  k_fold;
    logic                  k_zero;
    logic signed [CW-1:0]  xf;
    logic [CW-1:0]         wmag;
    logic [CW-1:0]         wsum;
    logic [15:0]           wsat;
    logic signed [15:0]    w_val;

    assign {k_c, k_root, k_fold, k_zero} = k_side;

    always_comb
    begin
        xf = k_fold ? -k_cord.x : k_cord.x;
        wmag = xf[CW-1] ? CW'(-xf) : CW'(xf);
        wsum = wmag + CW'(32768);
        wsat = (wsum[CW-1:16] > (CW-16)'(QONE)) ? 16'(QONE) : wsum[31:16];
        w_val = xf[CW-1] ? -$signed(wsat) : $signed(wsat);
    end

    logic                    d_vld_reg;
    logic signed [NUM_W-1:0] d_prod_reg [0:LANES-1];
    logic [ROOT_W-1:0]       d_root_reg;
    logic [DSIDE_W-1:0]      d_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (en)
            d_vld_reg <= k_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_prod_reg[0] <= k_cord.y * k_c.rot_x;
            d_prod_reg[1] <= k_cord.y * k_c.rot_y;
            d_prod_reg[2] <= k_cord.y * k_c.rot_z;
            d_root_reg <= k_root;
            d_side_reg <= {w_val, k_zero};
        end
    end

    // Divide each scaled part by the angle, rounding half away from zero
    logic               v_vld;
    logic [Q_W-1:0]     v_q   [0:LANES-1];
    logic               v_neg [0:LANES-1];
    logic [DSIDE_W-1:0] v_side;

    rvq_divide #(.SIDE_W(DSIDE_W)) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_vld_reg),
        .in_prod   (d_prod_reg),
        .in_root   (d_root_reg),
        .in_side   (d_side_reg),
        .out_valid (v_vld),
        .out_q     (v_q),
        .out_neg   (v_neg),
        .out_side  (v_side)
    );

    // Output stage: saturate, apply sign, force identity for a zero vector
    logic signed [15:0] v_w;
    logic               v_zero;
    logic signed [15:0] part [0:LANES-1];
    logic [15:0]        qs;
    rvq_out_t           quat_next;
    rvq_out_t           quat_reg;
    logic               quat_valid_reg;

    assign {v_w, v_zero} = v_side;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            qs = (v_q[l] > Q_W'(QONE)) ? 16'(QONE) : v_q[l];
            part[l] = v_neg[l] ? -$signed(qs) : $signed(qs);
            if (v_zero)
                part[l] = '0;
        end
        quat_next.quat_w = v_zero ? 16'(QONE) : v_w;
        quat_next.quat_x = part[0];
        quat_next.quat_y = part[1];
        quat_next.quat_z = part[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quat_valid_reg <= 1'b0;
        else if (en)
            quat_valid_reg <= v_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quat_reg <= quat_next;
    end

    assign quat_valid = quat_valid_reg;
    assign quat = quat_reg;

endmodule

[rtl/rvq_checker.sv]
// Port-level checks of the rotation vector to quaternion block, with bind
`include "assert_macros.svh"

module rvq_checker import rvq_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     rot_valid,
    input logic     rot_ready,
    input rvq_in_t  rot,
    input logic     quat_valid,
    input logic     quat_ready,
    input rvq_out_t quat
);

    logic rot_live;
    assign rot_live = rot_valid || (rot == rot);

    // A stalled result beat stays offered
    `ASSERT_IMPL(a_hold, clk, rst_n, quat_valid && !quat_ready, ##1 quat_valid)

    // With no result waiting, input is always taken
    `ASSERT_IMPL(a_ready, clk, rst_n, !quat_valid && rot_live, rot_ready)

    // Every part stays inside the unit range
    `ASSERT_IMPL(a_range, clk, rst_n, quat_valid,
        quat.quat_w <= 16384 && quat.quat_w >= -16384 &&
        quat.quat_x <= 16384 && quat.quat_x >= -16384 &&
        quat.quat_y <= 16384 && quat.quat_y >= -16384 &&
        quat.quat_z <= 16384 && quat.quat_z >= -16384)

    // A stalled receiver stalls the input side too
    `ASSERT_CLK(a_stall, clk, rst_n, !(quat_valid && !quat_ready && rot_ready))

endmodule

bind rotation_vector_to_quaternion rvq_checker u_rvq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rot_valid  (rot_valid),
    .rot_ready  (rot_ready),
    .rot        (rot),
    .quat_valid (quat_valid),
    .quat_ready (quat_ready),
    .quat       (quat)
);
